// ===== hdl/i2cte_pkg.sv =====
`default_nettype none

package i2cte_pkg;

    localparam int NUM_TARGETS_DEF = 4;
    localparam int MAX_SLOTS       = 4;
    localparam int ADDR_W          = 7;
    localparam int MASK_W          = 4;
    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 4;
    localparam int SLOT_W          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK   = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/i2c_target_bus_engine.sv =====
// i2c target bus engine
// one input beat per sample of the bus lines (clock, data) plus the active
// peripheral's answers (read_ready/read_byte, write_accept); one result beat
// per input beat carrying the driven data line and the session strobes.
// input channel: i_in_valid/o_in_ready, result channel: o_out_valid/i_out_ready.
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// indexes 0..3 are the slot addresses, 4 the enable mask, others are dropped.
// o_cfg_ready is always high; write only while no beat is in flight.
// a beat is registered at the input, then the bus step runs combinationally
// into the result register. throughput: one beat per cycle while the result
// stage is not stalled, set by the combinational edge detect, address compare
// and state update between the registers. a stalled result stage holds its
// beat; the input register still takes one more beat, after which o_in_ready
// drops until the result is taken.
// reset (synchronous, active low) clears the bus state, the configuration
// and both pipeline stages.
`default_nettype none

module i2c_target_bus_engine
    import i2cte_pkg::*;
#(
    parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_clock_pulled,
    input  wire logic                  i_data_pulled,
    input  wire logic                  i_read_ready,
    input  wire logic [BYTE_W-1:0]     i_read_byte,
    input  wire logic                  i_write_accept,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_data_line_pulled,
    output logic                       o_start_strobe,
    output logic                       o_start_is_read,
    output logic [SLOT_W-1:0]          o_target_index,
    output logic                       o_stop_strobe,
    output logic                       o_write_strobe,
    output logic [BYTE_W-1:0]          o_write_byte,
    output logic                       o_read_strobe
);

    localparam int SLOTS = (NUM_TARGETS < MAX_SLOTS) ? NUM_TARGETS : MAX_SLOTS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_RECV,
        PH_RACK,
        PH_BACK
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_START,
        EV_STOP,
        EV_ZERO,
        EV_ONE,
        EV_DONE
    } t_event;

    // configuration
    logic [ADDR_W-1:0] r_addr [SLOTS];
    logic [MASK_W-1:0] r_mask;

    // input stage
    logic              r_in_valid;
    logic              r_clock;
    logic              r_data;
    logic              r_rd_ready;
    logic [BYTE_W-1:0] r_rd_byte;
    logic              r_wr_accept;

    // bus state
    logic              r_last_clock, n_last_clock;
    logic              r_last_data, n_last_data;
    logic              r_within_bit, n_within_bit;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_shift_in, n_shift_in;
    logic [CNT_W-1:0]  r_bits_captured, n_bits_captured;
    logic [BYTE_W-1:0] r_shift_out, n_shift_out;
    logic [CNT_W-1:0]  r_bits_to_send, n_bits_to_send;
    logic              r_session, n_session;
    logic [SLOT_W-1:0] r_slot, n_slot;

    // result stage
    logic              r_out_valid;
    logic              r_line;
    logic              r_start;
    logic              r_is_read;
    logic              r_stop;
    logic              r_wstrobe;
    logic [BYTE_W-1:0] r_wbyte;
    logic              r_rstrobe;

    logic              n_line;
    logic              n_start;
    logic              n_is_read;
    logic              n_stop;
    logic              n_wstrobe;
    logic [BYTE_W-1:0] n_wbyte;
    logic              n_rstrobe;

    t_event            ev;
    logic              advance;
    logic [BYTE_W-1:0] cap_si;
    logic [CNT_W-1:0]  cap_bc;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [CNT_W-1:0]  e_bits_to_send;
    logic [BYTE_W-1:0] e_shift_out;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // edge and condition detect
    always_comb begin
        ev             = EV_NONE;
        n_last_clock   = r_last_clock;
        n_last_data    = r_last_data;
        n_within_bit   = r_within_bit;
        e_bits_to_send = r_bits_to_send;
        e_shift_out    = r_shift_out;
        if (r_clock != r_last_clock || r_data != r_last_data) begin
            n_last_clock = r_clock;
            n_last_data  = r_data;
            if (r_bits_to_send != '0) begin
                if (!r_last_clock && r_clock) begin
                    e_bits_to_send = r_bits_to_send - CNT_W'(1);
                    e_shift_out    = {r_shift_out[BYTE_W-2:0], 1'b0};
                    if (r_bits_to_send == CNT_W'(1)) begin
                        ev = EV_DONE;
                    end
                end
            end else if (!r_clock && r_last_data != r_data) begin
                n_within_bit = 1'b0;
                ev = r_data ? EV_START : EV_STOP;
            end else if (r_clock != r_last_clock) begin
                if (!r_clock) begin
                    n_within_bit = 1'b1;
                end else if (r_within_bit) begin
                    n_within_bit = 1'b0;
                    ev = r_data ? EV_ZERO : EV_ONE;
                end
            end
        end
    end

    assign cap_si = {r_shift_in[BYTE_W-2:0], ev != EV_ZERO};
    assign cap_bc = r_bits_captured + CNT_W'(1);

    // lowest enabled slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i] && r_addr[i] == cap_si[BYTE_W-1:1]) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    // protocol handling
    always_comb begin
        n_phase         = r_phase;
        n_shift_in      = r_shift_in;
        n_bits_captured = r_bits_captured;
        n_shift_out     = e_shift_out;
        n_bits_to_send  = e_bits_to_send;
        n_session       = r_session;
        n_slot          = r_slot;
        n_start         = 1'b0;
        n_is_read       = 1'b0;
        n_stop          = 1'b0;
        n_wstrobe       = 1'b0;
        n_wbyte         = '0;
        n_rstrobe       = 1'b0;
        if (ev == EV_START) begin
            n_phase         = PH_ADDR;
            n_shift_in      = '0;
            n_bits_captured = '0;
            n_session       = 1'b0;
        end else if (ev == EV_STOP) begin
            n_stop          = r_session;
            n_phase         = PH_IDLE;
            n_shift_in      = '0;
            n_bits_captured = '0;
            n_session       = 1'b0;
        end else if (ev != EV_NONE) begin
            case (r_phase)
                PH_ADDR: begin
                    n_shift_in      = cap_si;
                    n_bits_captured = cap_bc;
                    if (cap_bc == CNT_W'(BYTE_W)) begin
                        n_phase = PH_IDLE;
                        if (hit) begin
                            n_session       = 1'b1;
                            n_slot          = hit_slot;
                            n_start         = 1'b1;
                            n_is_read       = cap_si[0];
                            n_shift_out     = '0;
                            n_bits_to_send  = CNT_W'(1);
                            n_phase         = cap_si[0] ? PH_RACK : PH_RECV;
                            n_shift_in      = '0;
                            n_bits_captured = '0;
                        end
                    end
                end
                PH_RECV: begin
                    if (ev != EV_DONE) begin
                        n_shift_in      = cap_si;
                        n_bits_captured = cap_bc;
                        if (cap_bc == CNT_W'(BYTE_W)) begin
                            n_wstrobe       = 1'b1;
                            n_wbyte         = cap_si;
                            n_shift_in      = '0;
                            n_bits_captured = '0;
                            if (r_wr_accept) begin
                                n_shift_out    = '0;
                                n_bits_to_send = CNT_W'(1);
                                n_phase        = PH_RECV;
                            end else begin
                                n_phase   = PH_IDLE;
                                n_session = 1'b0;
                            end
                        end
                    end
                end
                PH_RACK, PH_BACK: begin
                    if (r_phase == PH_BACK && ev != EV_DONE && ev != EV_ZERO) begin
                        n_phase         = PH_IDLE;
                        n_shift_in      = '0;
                        n_bits_captured = '0;
                        n_session       = 1'b0;
                    end else if ((r_phase == PH_RACK && ev == EV_DONE) ||
                                 (r_phase == PH_BACK && ev == EV_ZERO)) begin
                        n_rstrobe       = 1'b1;
                        n_shift_in      = '0;
                        n_bits_captured = '0;
                        if (r_rd_ready) begin
                            n_shift_out    = r_rd_byte;
                            n_bits_to_send = CNT_W'(BYTE_W);
                            n_phase        = PH_BACK;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_line = r_data || (n_bits_to_send != '0 && !n_shift_out[BYTE_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_addr[i] <= '0;
            end
            r_mask          <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last_clock    <= 1'b0;
            r_last_data     <= 1'b0;
            r_within_bit    <= 1'b0;
            r_phase         <= PH_IDLE;
            r_shift_in      <= '0;
            r_bits_captured <= '0;
            r_shift_out     <= '0;
            r_bits_to_send  <= '0;
            r_session       <= 1'b0;
            r_slot          <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index <= CFG_TARGET_ADDR_3) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i_cfg_index == CFG_IDX_W'(i)) begin
                            r_addr[i] <= i_cfg_data[ADDR_W-1:0];
                        end
                    end
                end else if (i_cfg_index == CFG_ENABLE_MASK) begin
                    r_mask <= i_cfg_data[MASK_W-1:0];
                end
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_clock     <= i_clock_pulled;
                    r_data      <= i_data_pulled;
                    r_rd_ready  <= i_read_ready;
                    r_rd_byte   <= i_read_byte;
                    r_wr_accept <= i_write_accept;
                end
            end

            if (advance) begin
                r_last_clock    <= n_last_clock;
                r_last_data     <= n_last_data;
                r_within_bit    <= n_within_bit;
                r_phase         <= n_phase;
                r_shift_in      <= n_shift_in;
                r_bits_captured <= n_bits_captured;
                r_shift_out     <= n_shift_out;
                r_bits_to_send  <= n_bits_to_send;
                r_session       <= n_session;
                r_slot          <= n_slot;
                r_out_valid     <= 1'b1;
                r_line          <= n_line;
                r_start         <= n_start;
                r_is_read       <= n_is_read;
                r_stop          <= n_stop;
                r_wstrobe       <= n_wstrobe;
                r_wbyte         <= n_wbyte;
                r_rstrobe       <= n_rstrobe;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_data_line_pulled = r_line;
    assign o_start_strobe     = r_start;
    assign o_start_is_read    = r_is_read;
    assign o_target_index     = r_slot;
    assign o_stop_strobe      = r_stop;
    assign o_write_strobe     = r_wstrobe;
    assign o_write_byte       = r_wbyte;
    assign o_read_strobe      = r_rstrobe;

endmodule

`default_nettype wire

// ===== hdl/i2cte_checker.sv =====
`default_nettype none

module i2cte_checker
    import i2cte_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_start_strobe,
    input wire logic                  o_start_is_read,
    input wire logic                  o_stop_strobe,
    input wire logic                  o_write_strobe,
    input wire logic [BYTE_W-1:0]     o_write_byte,
    input wire logic                  o_read_strobe
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // no beat in flight right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // direction only comes with a start
    a_read_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_is_read |-> o_start_strobe)
        else $error("direction without start");

    // one bus event per beat
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_start_strobe, o_stop_strobe,
                                    o_write_strobe, o_read_strobe}) <= 1)
        else $error("several strobes in one beat");

    // byte is zero when not offered
    a_wbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_strobe |-> o_write_byte == '0)
        else $error("write byte without strobe");

endmodule

bind i2c_target_bus_engine i2cte_checker u_i2cte_checker (.*);

`default_nettype wire
